// ===== rtl/nfbta_pkg.sv =====
// shared types and constants of the next-fit boundary-tag allocator
`default_nettype none
package nfbta_pkg;

  localparam int unsigned HEAP_BYTES = 65536;
  localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
  localparam int unsigned IDX_W      = $clog2(HEAP_WORDS);
  // byte offsets are carried signed and wide enough that no sum of tags wraps
  localparam int unsigned AW         = 36;
  localparam int unsigned OFF_W      = 17;
  localparam int unsigned NEED_W     = 18;

  localparam int unsigned MIN_BLOCK   = 16;
  localparam int unsigned CHUNK_RESET = 4096;
  localparam int unsigned LIST_START  = 8;
  localparam int unsigned FIRST_BP    = 16;
  localparam int unsigned BREAK_RESET = FIRST_BP + CHUNK_RESET;

  // word indexes of the reset layout
  localparam int unsigned PRO_HDR_IDX = 1;
  localparam int unsigned PRO_FTR_IDX = 2;
  localparam int unsigned BLK_HDR_IDX = (FIRST_BP - 4) / 4;
  localparam int unsigned BLK_FTR_IDX = (FIRST_BP + CHUNK_RESET - 8) / 4;
  localparam int unsigned EPI_IDX     = (FIRST_BP + CHUNK_RESET - 4) / 4;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef enum logic [5:0] {
    CMD_NOP,
    CMD_INIT,
    CMD_ACCEPT,
    CMD_S_RD,
    CMD_S_CHK,
    CMD_G_CHK,
    CMD_G_WH,
    CMD_G_WF,
    CMD_G_WE,
    CMD_M_RPF,
    CMD_M_RB,
    CMD_M_RPP,
    CMD_M_RPA,
    CMD_M_RNA,
    CMD_M_DEC,
    CMD_M1_WH,
    CMD_M1_RH,
    CMD_M1_WF,
    CMD_M2_WF,
    CMD_M2_WP,
    CMD_M3_RN,
    CMD_M3_WN,
    CMD_C_RD,
    CMD_C_DEC,
    CMD_C_S1,
    CMD_C_S2,
    CMD_C_S3,
    CMD_C_S4,
    CMD_C_N1,
    CMD_C_N2,
    CMD_F_RH,
    CMD_F_WH,
    CMD_F_WF
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic init_last;
    logic in_free;
    logic in_zero;
    logic s_end;
    logic s_fit;
    logic g_fit;
    logic pa;
    logic na;
    logic split;
  } sts_t;

  function automatic logic [31:0] init_word(input logic [IDX_W-1:0] idx);
    logic [31:0] w;
    w = '0;
    if (idx == IDX_W'(PRO_HDR_IDX) || idx == IDX_W'(PRO_FTR_IDX)) w = 32'd9;
    else if (idx == IDX_W'(BLK_HDR_IDX) || idx == IDX_W'(BLK_FTR_IDX)) w = 32'(CHUNK_RESET);
    else if (idx == IDX_W'(EPI_IDX)) w = 32'd1;
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/nfbta_ctrl.sv =====
// sequencer of the allocator: at most one step of heap access per state
`default_nettype none
module nfbta_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire nfbta_pkg::sts_t sts_i,
  output nfbta_pkg::ctl_t    ctl_o
);

  typedef enum logic [5:0] {
    ST_INIT, ST_IDLE, ST_S_RD, ST_S_CHK, ST_G_CHK, ST_G_WH, ST_G_WF, ST_G_WE,
    ST_M_RPF, ST_M_RB, ST_M_RPP, ST_M_RPA, ST_M_RNA, ST_M_DEC,
    ST_M1_WH, ST_M1_RH, ST_M1_WF, ST_M2_WF, ST_M2_WP, ST_M3_RN, ST_M3_WN,
    ST_C_RD, ST_C_DEC, ST_C_S1, ST_C_S2, ST_C_S3, ST_C_S4, ST_C_N1, ST_C_N2,
    ST_F_RH, ST_F_WH, ST_F_WF, ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   is_free_q, is_free_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  state_e after_merge;

  assign accept      = (state_q == ST_IDLE) && in_valid_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign after_merge = is_free_q ? ST_RESP : ST_C_RD;

  always_comb begin
    state_d       = state_q;
    is_free_d     = is_free_q;
    ctl_o.cmd      = nfbta_pkg::CMD_NOP;
    ctl_o.out_load = 1'b0;
    case (state_q)
      ST_INIT: begin
        ctl_o.cmd = nfbta_pkg::CMD_INIT;
        if (sts_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          ctl_o.cmd = nfbta_pkg::CMD_ACCEPT;
          is_free_d = sts_i.in_free;
          if (sts_i.in_free) state_d = ST_F_RH;
          else if (sts_i.in_zero) state_d = ST_RESP;
          else state_d = ST_S_RD;
        end
      end
      ST_S_RD: begin
        ctl_o.cmd = nfbta_pkg::CMD_S_RD;
        state_d   = ST_S_CHK;
      end
      ST_S_CHK: begin
        ctl_o.cmd = nfbta_pkg::CMD_S_CHK;
        if (sts_i.s_end) state_d = ST_G_CHK;
        else if (sts_i.s_fit) state_d = ST_C_RD;
        else state_d = ST_S_RD;
      end
      ST_G_CHK: begin
        ctl_o.cmd = nfbta_pkg::CMD_G_CHK;
        state_d   = sts_i.g_fit ? ST_G_WH : ST_RESP;
      end
      ST_G_WH: begin ctl_o.cmd = nfbta_pkg::CMD_G_WH; state_d = ST_G_WF; end
      ST_G_WF: begin ctl_o.cmd = nfbta_pkg::CMD_G_WF; state_d = ST_G_WE; end
      ST_G_WE: begin ctl_o.cmd = nfbta_pkg::CMD_G_WE; state_d = ST_M_RPF; end
      ST_M_RPF: begin ctl_o.cmd = nfbta_pkg::CMD_M_RPF; state_d = ST_M_RB; end
      ST_M_RB: begin ctl_o.cmd = nfbta_pkg::CMD_M_RB; state_d = ST_M_RPP; end
      ST_M_RPP: begin ctl_o.cmd = nfbta_pkg::CMD_M_RPP; state_d = ST_M_RPA; end
      ST_M_RPA: begin ctl_o.cmd = nfbta_pkg::CMD_M_RPA; state_d = ST_M_RNA; end
      ST_M_RNA: begin ctl_o.cmd = nfbta_pkg::CMD_M_RNA; state_d = ST_M_DEC; end
      ST_M_DEC: begin
        ctl_o.cmd = nfbta_pkg::CMD_M_DEC;
        if (sts_i.pa && sts_i.na) state_d = after_merge;
        else if (sts_i.pa) state_d = ST_M1_WH;
        else if (sts_i.na) state_d = ST_M2_WF;
        else state_d = ST_M3_RN;
      end
      ST_M1_WH: begin ctl_o.cmd = nfbta_pkg::CMD_M1_WH; state_d = ST_M1_RH; end
      ST_M1_RH: begin ctl_o.cmd = nfbta_pkg::CMD_M1_RH; state_d = ST_M1_WF; end
      ST_M1_WF: begin ctl_o.cmd = nfbta_pkg::CMD_M1_WF; state_d = after_merge; end
      ST_M2_WF: begin ctl_o.cmd = nfbta_pkg::CMD_M2_WF; state_d = ST_M2_WP; end
      ST_M2_WP: begin ctl_o.cmd = nfbta_pkg::CMD_M2_WP; state_d = after_merge; end
      ST_M3_RN: begin ctl_o.cmd = nfbta_pkg::CMD_M3_RN; state_d = ST_M3_WN; end
      ST_M3_WN: begin ctl_o.cmd = nfbta_pkg::CMD_M3_WN; state_d = ST_M2_WP; end
      ST_C_RD: begin ctl_o.cmd = nfbta_pkg::CMD_C_RD; state_d = ST_C_DEC; end
      ST_C_DEC: begin
        ctl_o.cmd = nfbta_pkg::CMD_C_DEC;
        state_d   = sts_i.split ? ST_C_S1 : ST_C_N1;
      end
      ST_C_S1: begin ctl_o.cmd = nfbta_pkg::CMD_C_S1; state_d = ST_C_S2; end
      ST_C_S2: begin ctl_o.cmd = nfbta_pkg::CMD_C_S2; state_d = ST_C_S3; end
      ST_C_S3: begin ctl_o.cmd = nfbta_pkg::CMD_C_S3; state_d = ST_C_S4; end
      ST_C_S4: begin ctl_o.cmd = nfbta_pkg::CMD_C_S4; state_d = ST_RESP; end
      ST_C_N1: begin ctl_o.cmd = nfbta_pkg::CMD_C_N1; state_d = ST_C_N2; end
      ST_C_N2: begin ctl_o.cmd = nfbta_pkg::CMD_C_N2; state_d = ST_RESP; end
      ST_F_RH: begin ctl_o.cmd = nfbta_pkg::CMD_F_RH; state_d = ST_F_WH; end
      ST_F_WH: begin ctl_o.cmd = nfbta_pkg::CMD_F_WH; state_d = ST_F_WF; end
      ST_F_WF: begin ctl_o.cmd = nfbta_pkg::CMD_F_WF; state_d = ST_M_RPF; end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      is_free_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      is_free_q   <= is_free_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/nfbta_datapath.sv =====
// heap store, block pointers, size arithmetic and result registers
`default_nettype none
module nfbta_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire nfbta_pkg::ctl_t            ctl_i,
  output nfbta_pkg::sts_t                 sts_o,
  input  wire logic                       opcode_i,
  input  wire logic [16:0]                request_bytes_i,
  input  wire logic [15:0]                free_address_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [16:0]                cfg_wdata_i,
  output logic [15:0]                     block_address_o,
  output logic [1:0]                      status_o
);

  localparam int unsigned AW  = nfbta_pkg::AW;
  localparam int unsigned IW  = nfbta_pkg::IDX_W;
  localparam int unsigned NW  = nfbta_pkg::NEED_W;
  localparam int unsigned OW  = nfbta_pkg::OFF_W;

  logic [31:0]    mem [nfbta_pkg::HEAP_WORDS];
  logic [31:0]    mem_q;
  logic           rd_oor_q;

  logic [IW-1:0]  init_q;
  logic [OW-1:0]  rover_q, break_q, chunk_q;
  logic           rover_valid_q;

  logic [AW-1:0]  bp_q, prv_q, nxt_q;
  logic [31:0]    sb_q, spp_q, sn_q, have_q;
  logic [33:0]    size_q;
  logic [NW-1:0]  need_q;
  logic           pa_q;
  logic [15:0]    res_bp_q, out_bp_q;
  logic [1:0]     res_st_q, out_st_q;

  logic [AW-1:0]  maddr;
  logic           mrd, mwr, minr;
  logic [31:0]    mwdata;
  logic [IW-1:0]  midx;
  logic [31:0]    rdata, rsz;
  logic [AW-1:0]  rsz_x, sb_x, sn_x, have_x, need_x, size_x;
  logic [33:0]    sum3;
  logic [NW-1:0]  need_in, req_x, ext;
  logic [15:0]    gw;
  logic [18:0]    gsz;
  logic [19:0]    gend;

  assign rdata  = rd_oor_q ? '0 : mem_q;
  assign rsz    = rdata & 32'hFFFF_FFF8;
  assign rsz_x  = AW'(rsz);
  assign sb_x   = AW'(sb_q);
  assign sn_x   = AW'(sn_q);
  assign have_x = AW'(have_q);
  assign need_x = AW'(need_q);
  assign size_x = AW'(size_q);
  assign sum3   = 34'(sb_q) + 34'(spp_q) + 34'(rsz);

  // rounded block size of the request, tags included
  assign req_x   = NW'(request_bytes_i);
  assign need_in = (request_bytes_i <= 17'd8) ? NW'(nfbta_pkg::MIN_BLOCK)
                                               : ((req_x + NW'(15)) & ~NW'(7));

  // heap extension: whole words, even count
  assign ext  = (need_q > NW'(chunk_q)) ? need_q : NW'(chunk_q);
  assign gw   = ext[NW-1:2];
  assign gsz  = {(17'(gw) + 17'(gw[0])), 2'b00};
  assign gend = 20'(break_q) + 20'(gsz);

  assign sts_o.init_last = (init_q == IW'(nfbta_pkg::HEAP_WORDS - 1));
  assign sts_o.in_free   = opcode_i;
  assign sts_o.in_zero   = (request_bytes_i == '0);
  assign sts_o.s_end     = (rsz == '0);
  assign sts_o.s_fit     = !rdata[0] && (rsz >= 32'(need_q));
  assign sts_o.g_fit     = (gend <= 20'(nfbta_pkg::HEAP_BYTES));
  assign sts_o.pa        = pa_q;
  assign sts_o.na        = rdata[0];
  assign sts_o.split     = (rsz >= 32'(need_q + NW'(nfbta_pkg::MIN_BLOCK)));

  // address and data of the heap port for each step
  always_comb begin
    maddr  = bp_q - AW'(4);
    mrd    = 1'b0;
    mwr    = 1'b0;
    mwdata = size_q[31:0];
    case (ctl_i.cmd)
      nfbta_pkg::CMD_INIT: begin
        maddr  = AW'({init_q, 2'b00});
        mwr    = 1'b1;
        mwdata = nfbta_pkg::init_word(init_q);
      end
      nfbta_pkg::CMD_S_RD, nfbta_pkg::CMD_M_RB, nfbta_pkg::CMD_M1_RH,
      nfbta_pkg::CMD_C_RD, nfbta_pkg::CMD_F_RH: mrd = 1'b1;
      nfbta_pkg::CMD_G_WH, nfbta_pkg::CMD_M1_WH: mwr = 1'b1;
      nfbta_pkg::CMD_G_WF, nfbta_pkg::CMD_F_WF: begin
        maddr = bp_q + size_x - AW'(8);
        mwr   = 1'b1;
      end
      nfbta_pkg::CMD_G_WE: begin
        maddr  = bp_q + size_x - AW'(4);
        mwr    = 1'b1;
        mwdata = 32'd1;
      end
      nfbta_pkg::CMD_M_RPF: begin
        maddr = bp_q - AW'(8);
        mrd   = 1'b1;
      end
      nfbta_pkg::CMD_M_RPP: begin
        maddr = prv_q - AW'(4);
        mrd   = 1'b1;
      end
      nfbta_pkg::CMD_M_RPA: begin
        maddr = prv_q + rsz_x - AW'(8);
        mrd   = 1'b1;
      end
      nfbta_pkg::CMD_M_RNA: begin
        maddr = nxt_q - AW'(4);
        mrd   = 1'b1;
      end
      nfbta_pkg::CMD_M1_WF: begin
        maddr = bp_q + rsz_x - AW'(8);
        mwr   = 1'b1;
      end
      nfbta_pkg::CMD_M2_WF: begin
        maddr = bp_q + sb_x - AW'(8);
        mwr   = 1'b1;
      end
      nfbta_pkg::CMD_M2_WP: begin
        maddr = prv_q - AW'(4);
        mwr   = 1'b1;
      end
      nfbta_pkg::CMD_M3_RN: begin
        maddr = nxt_q + sn_x - AW'(8);
        mrd   = 1'b1;
      end
      nfbta_pkg::CMD_M3_WN: begin
        maddr  = nxt_q + sn_x - AW'(8);
        mwr    = 1'b1;
        mwdata = sum3[31:0];
      end
      nfbta_pkg::CMD_C_S1: begin
        mwr    = 1'b1;
        mwdata = 32'(need_q) | 32'd1;
      end
      nfbta_pkg::CMD_C_S2: begin
        maddr  = bp_q + need_x - AW'(8);
        mwr    = 1'b1;
        mwdata = 32'(need_q) | 32'd1;
      end
      nfbta_pkg::CMD_C_S3: begin
        maddr  = bp_q + need_x - AW'(4);
        mwr    = 1'b1;
        mwdata = have_q - 32'(need_q);
      end
      nfbta_pkg::CMD_C_S4: begin
        maddr  = bp_q + have_x - AW'(8);
        mwr    = 1'b1;
        mwdata = have_q - 32'(need_q);
      end
      nfbta_pkg::CMD_C_N1: begin
        mwr    = 1'b1;
        mwdata = have_q | 32'd1;
      end
      nfbta_pkg::CMD_C_N2: begin
        maddr  = bp_q + have_x - AW'(8);
        mwr    = 1'b1;
        mwdata = have_q | 32'd1;
      end
      nfbta_pkg::CMD_F_WH: begin
        mwr    = 1'b1;
        mwdata = rsz;
      end
      default: ;
    endcase
  end

  // outside the store: reads give zero, writes are dropped
  assign minr = !maddr[AW-1] && (maddr < AW'(nfbta_pkg::HEAP_BYTES));
  assign midx = maddr[IW+1:2];

  always_ff @(posedge clk_i) begin
    if (mwr && minr) mem[midx] <= mwdata;
    if (mrd) begin
      mem_q    <= mem[midx];
      rd_oor_q <= !minr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q        <= '0;
      rover_q       <= OW'(nfbta_pkg::FIRST_BP);
      rover_valid_q <= 1'b1;
      break_q       <= OW'(nfbta_pkg::BREAK_RESET);
      chunk_q       <= OW'(nfbta_pkg::CHUNK_RESET);
    end else begin
      if (cfg_we_i) chunk_q <= cfg_wdata_i;
      case (ctl_i.cmd)
        nfbta_pkg::CMD_INIT: init_q <= init_q + IW'(1);
        nfbta_pkg::CMD_S_CHK: begin
          if (sts_o.s_end) rover_valid_q <= 1'b0;
          else if (sts_o.s_fit) begin
            rover_q       <= bp_q[OW-1:0];
            rover_valid_q <= 1'b1;
          end
        end
        nfbta_pkg::CMD_G_CHK: if (sts_o.g_fit) break_q <= gend[OW-1:0];
        nfbta_pkg::CMD_M1_WF: begin
          rover_q       <= bp_q[OW-1:0];
          rover_valid_q <= 1'b1;
        end
        nfbta_pkg::CMD_M2_WP: begin
          rover_q       <= prv_q[OW-1:0];
          rover_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_bp_q <= res_bp_q;
      out_st_q <= res_st_q;
    end
    case (ctl_i.cmd)
      nfbta_pkg::CMD_ACCEPT: begin
        need_q   <= need_in;
        res_bp_q <= '0;
        res_st_q <= (!opcode_i && request_bytes_i == '0) ? nfbta_pkg::STATUS_ZERO
                                                          : nfbta_pkg::STATUS_DONE;
        if (opcode_i) bp_q <= AW'(free_address_i);
        else if (rover_valid_q) bp_q <= AW'(rover_q);
        else bp_q <= AW'(nfbta_pkg::LIST_START);
      end
      nfbta_pkg::CMD_S_CHK: if (!sts_o.s_end && !sts_o.s_fit) bp_q <= bp_q + rsz_x;
      nfbta_pkg::CMD_G_CHK: begin
        if (sts_o.g_fit) begin
          bp_q   <= AW'(break_q);
          size_q <= 34'(gsz);
        end else begin
          res_st_q <= nfbta_pkg::STATUS_FULL;
        end
      end
      nfbta_pkg::CMD_M_RB: prv_q <= bp_q - rsz_x;
      nfbta_pkg::CMD_M_RPP: begin
        sb_q  <= rsz;
        nxt_q <= bp_q + rsz_x;
      end
      nfbta_pkg::CMD_M_RPA: spp_q <= rsz;
      nfbta_pkg::CMD_M_RNA: pa_q <= rdata[0];
      nfbta_pkg::CMD_M_DEC: begin
        sn_q   <= rsz;
        size_q <= pa_q ? (34'(sb_q) + 34'(rsz)) : (34'(sb_q) + 34'(spp_q));
      end
      nfbta_pkg::CMD_M2_WP: bp_q <= prv_q;
      nfbta_pkg::CMD_M3_WN: size_q <= sum3;
      nfbta_pkg::CMD_C_DEC: begin
        have_q   <= rsz;
        res_bp_q <= bp_q[15:0];
      end
      nfbta_pkg::CMD_F_WH: size_q <= 34'(rsz);
      default: ;
    endcase
  end

  assign block_address_o = out_bp_q;
  assign status_o        = out_st_q;

endmodule
`default_nettype wire

// ===== rtl/next_fit_boundary_tag_allocator.sv =====
// top level of the next-fit boundary-tag heap allocator
`default_nettype none
// a free rewrites the block's tags and merges it with free neighbours; a zero-size request
// is answered without touching the heap; an allocation walks block headers, then marks the
//   block, splitting it if large enough; an extension grows the heap first, out of space ends the walk
// throughput: one request at a time; the single-port heap store sets the pace
// reset: a clearing pass writes the initial heap layout over all 16384 words,
//   during which no request is taken (config writes are)
module next_fit_boundary_tag_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [16:0] request_bytes_i,
  input  wire logic [15:0] free_address_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      block_address_o,
  output logic [1:0]       status_o,
  // minimum heap extension register
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i
);

  // controller walks the steps, datapath owns the heap and all pointers
  nfbta_pkg::ctl_t ctl;
  nfbta_pkg::sts_t sts;

  nfbta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // result register lives in the datapath, so a new request can start
  // while the previous result waits to be taken
  nfbta_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .opcode_i        (opcode_i),
    .request_bytes_i (request_bytes_i),
    .free_address_i  (free_address_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .block_address_o (block_address_o),
    .status_o        (status_o)
  );

endmodule
`default_nettype wire

// ===== rtl/nfbta_checker.sv =====
// port-level checks of the allocator, bound to the top level
`default_nettype none
module nfbta_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] block_address_o,
  input wire logic [1:0]  status_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(block_address_o)
      && $stable(status_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= nfbta_pkg::STATUS_FULL)
    else $error("undefined status code");

  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != nfbta_pkg::STATUS_DONE |-> block_address_o == 16'd0)
    else $error("failed request returned an address");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

endmodule

bind next_fit_boundary_tag_allocator nfbta_checker u_nfbta_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .block_address_o (block_address_o),
  .status_o        (status_o)
);
`default_nettype wire
